### src/rbfr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbfr_pkg
// Types and codes shared by the rail bus frame receiver modules.
// ----------------------------------------------------------------------------
package rbfr_pkg;

    localparam int NUM_SW = 14;
    localparam int NUM_BLK = 14;

    typedef enum logic [1:0] {
        CMD_BYTE = 2'd0,
        CMD_TICK = 2'd1,
        CMD_SENT = 2'd2,
        CMD_NONE = 2'd3
    } cmd_t;

    typedef enum logic [3:0] {
        EV_FEEDBACK  = 4'd0,
        EV_ACK       = 4'd1,
        EV_FAILURE   = 4'd2,
        EV_POWER_OFF = 4'd3,
        EV_POWER_ON  = 4'd4,
        EV_TRAINS    = 4'd5,
        EV_BUSY      = 4'd6,
        EV_UNHANDLED = 4'd7,
        EV_TIMEOUT   = 4'd8
    } event_t;

    localparam logic [1:0] REG_TIMEOUT = 2'd0;
    localparam logic [1:0] REG_MAP_A   = 2'd1;
    localparam logic [1:0] REG_MAP_B   = 2'd2;

    localparam logic [7:0] HDR_FB_LO  = 8'h40;
    localparam logic [7:0] HDR_FB_HI  = 8'h60;
    localparam logic [7:0] HDR_STAT   = 8'h01;
    localparam logic [7:0] HDR_POWER  = 8'h61;
    localparam logic [7:0] HDR_TRAINS = 8'h81;
    localparam logic [7:0] FB_ADDR_A  = 8'h40;
    localparam logic [7:0] FB_ADDR_B  = 8'h41;

    typedef struct packed {
        logic [1:0]  command;
        logic [7:0]  rx_byte;
        logic [15:0] elapsed_ms;
    } in_item_t;

    typedef struct packed {
        logic [3:0]  event_kind;
        logic        checksum_ok;
        logic        request_all_off;
        logic        request_resend;
        logic        track_power_on;
        logic        command_pending;
        logic [27:0] switch_state_vector;
        logic [13:0] block_occupied_vector;
        logic [13:0] block_known_vector;
        logic        switch_report_error;
    } out_item_t;

    // Front to back: one classified job
    typedef enum logic [1:0] {
        JOB_FRAME   = 2'd0,
        JOB_TIMEOUT = 2'd1,
        JOB_ARM     = 2'd2
    } job_kind_t;

    typedef struct packed {
        job_kind_t  kind;
        logic       ck_ok;
        logic [7:0] hdr;
        logic [7:0] d1;
        logic [2:0] pairs;
    } job_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_PAIR,
        BK_EMIT
    } bk_state_t;

endpackage

### src/rbfr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbfr_front
// Frames bytes, keeps checksum and the pending timer, and hands frame ends,
// timeouts and command-sent notices to the back end as jobs.
// ----------------------------------------------------------------------------
module rbfr_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  rbfr_pkg::in_item_t  in_item,
    output logic                in_ready,
    input  logic [15:0]         timeout_limit,
    output logic                job_valid,
    output rbfr_pkg::job_t      job,
    input  logic                job_ready,
    // frame store write port
    output logic                st_we,
    output logic [3:0]          st_waddr,
    output logic [7:0]          st_wdata
);
    import rbfr_pkg::*;

    logic [4:0]  cnt_reg, cnt_next;
    logic [4:0]  len_reg, len_next;
    logic [7:0]  ck_reg, ck_next;
    logic [7:0]  hdr_reg, hdr_next;
    logic [7:0]  d1_reg, d1_next;
    logic [16:0] el_reg, el_next;
    logic        pend_reg, pend_next;
    logic        jv_reg, jv_next;
    job_t        job_reg, job_next;

    logic        take;
    logic [4:0]  len_cur;
    logic [7:0]  ck_cur;
    logic [4:0]  cnt_inc;
    logic [16:0] el_sum;

    // Hold input while a job waits; the back end needs the frame store intact
    assign in_ready = !jv_reg;
    assign take     = in_valid && in_ready;
    assign job_valid = jv_reg;
    assign job       = job_reg;

    always_comb
    begin
        len_cur = (cnt_reg == 5'd0) ? ((in_item.rx_byte[3:0] == 4'hf) ? 5'd17
                  : {1'b0, in_item.rx_byte[3:0]} + 5'd2) : len_reg;
        ck_cur  = (cnt_reg == 5'd0) ? 8'h00 : ck_reg;
        cnt_inc = cnt_reg + 5'd1;
        el_sum  = el_reg + {1'b0, in_item.elapsed_ms};
    end

    always_comb
    begin
        cnt_next  = cnt_reg;
        len_next  = len_reg;
        ck_next   = ck_reg;
        hdr_next  = hdr_reg;
        d1_next   = d1_reg;
        el_next   = el_reg;
        pend_next = pend_reg;
        jv_next   = jv_reg && !job_ready;
        job_next  = job_reg;
        st_we     = 1'b0;
        st_waddr  = cnt_reg[3:0];
        st_wdata  = in_item.rx_byte;
        if (take)
        begin
            unique case (cmd_t'(in_item.command))
                CMD_BYTE:
                begin
                    len_next = len_cur;
                    st_we    = !cnt_reg[4];
                    if (cnt_reg == 5'd0)
                        hdr_next = in_item.rx_byte;
                    if (cnt_reg == 5'd1)
                        d1_next = in_item.rx_byte;
                    if (cnt_inc >= len_cur)
                    begin
                        cnt_next      = 5'd0;
                        ck_next       = ck_cur;
                        jv_next       = 1'b1;
                        job_next.kind = JOB_FRAME;
                        job_next.ck_ok = (in_item.rx_byte == ck_cur);
                        job_next.hdr  = (cnt_reg == 5'd0) ? in_item.rx_byte : hdr_reg;
                        job_next.d1   = (cnt_reg == 5'd1) ? in_item.rx_byte : d1_reg;
                        job_next.pairs = (len_cur >= 5'd16) ? 3'd7
                                         : 3'((len_cur - 5'd2) >> 1);
                    end
                    else
                    begin
                        cnt_next = cnt_inc;
                        ck_next  = ck_cur ^ in_item.rx_byte;
                    end
                end
                CMD_TICK:
                begin
                    el_next = el_sum;
                    if (el_sum > {1'b0, timeout_limit})
                    begin
                        el_next   = 17'd0;
                        pend_next = 1'b0;
                        if (pend_reg)
                        begin
                            jv_next       = 1'b1;
                            job_next.kind = JOB_TIMEOUT;
                        end
                    end
                end
                CMD_SENT:
                begin
                    pend_next     = 1'b1;
                    el_next       = 17'd0;
                    jv_next       = 1'b1;
                    job_next.kind = JOB_ARM;
                end
                default: ;
            endcase
        end
        // an ack frame clears the pending flag here as the job leaves
        if (jv_reg && job_ready && job_reg.kind == JOB_FRAME && job_reg.ck_ok
            && job_reg.hdr == HDR_STAT && job_reg.d1 == 8'h04)
            pend_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= 5'd0;
            len_reg  <= 5'd0;
            ck_reg   <= 8'h00;
            el_reg   <= 17'd0;
            pend_reg <= 1'b0;
            jv_reg   <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            len_reg  <= len_next;
            ck_reg   <= ck_next;
            el_reg   <= el_next;
            pend_reg <= pend_next;
            jv_reg   <= jv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hdr_reg <= hdr_next;
        d1_reg  <= d1_next;
        job_reg <= job_next;
    end

endmodule

### src/rbfr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbfr_back
// Carries out jobs: walks feedback pairs from the frame store, address byte
// then value byte, keeps switch, occupancy and power state, and builds result items.
// ----------------------------------------------------------------------------
module rbfr_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 job_valid,
    input  rbfr_pkg::job_t       job,
    output logic                 job_ready,
    input  logic [31:0]          map_a,
    input  logic [31:0]          map_b,
    input  logic                 st_we,
    input  logic [3:0]           st_waddr,
    input  logic [7:0]           st_wdata,
    output logic                 res_valid,
    output rbfr_pkg::out_item_t  res,
    input  logic                 res_ready
);
    import rbfr_pkg::*;

    logic [7:0] store_mem [16];
    logic [7:0] addr_q, val_q;

    bk_state_t state_reg, state_next;
    logic [2:0] pidx_reg, pidx_next;
    logic [2:0] pairs_reg, pairs_next;
    logic       swerr_reg, swerr_next;
    logic       pend_reg, pend_next;
    logic       pwr_reg, pwr_next;
    logic [1:0] sw_reg [NUM_SW];
    logic [1:0] sw_next [NUM_SW];
    logic [NUM_BLK-1:0] occ_reg, occ_next, kn_reg, kn_next;
    logic       rv_reg, rv_next;
    out_item_t  res_reg, res_next;

    logic [3:0] rd_addr;
    logic       rd_en;
    logic       emit;
    event_t     ev;
    logic       e_ck, e_off, e_rs;
    logic       rd_ph_reg, rd_ph_next;
    logic       apply_reg;

    // pair p: address at 1+2p, value at 2+2p; read one byte per cycle
    assign rd_addr = {pidx_reg, 1'b0} + {3'd0, ~rd_ph_reg} + 4'd0
                     + (rd_ph_reg ? 4'd2 : 4'd0);
    assign rd_en   = (state_reg == BK_PAIR);

    always_ff @(posedge clk)
    begin
        if (st_we)
            store_mem[st_waddr] <= st_wdata;
        if (rd_en)
        begin
            if (rd_ph_reg)
                val_q <= store_mem[rd_addr];
            else
                addr_q <= store_mem[rd_addr];
        end
    end

    // hold new jobs while a result waits
    assign job_ready = (state_reg == BK_IDLE) && !rv_reg;

    assign res_valid = rv_reg;
    assign res       = res_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
                if (job_valid && job_ready)
                begin
                    if (job.kind == JOB_FRAME && job.ck_ok && job.hdr >= HDR_FB_LO
                        && job.hdr <= HDR_FB_HI && job.pairs != 3'd0)
                        state_next = BK_PAIR;
                    else if (job.kind != JOB_ARM)
                        state_next = BK_EMIT;
                end
            BK_PAIR:
                if (rd_ph_reg && pidx_reg == pairs_reg - 3'd1)
                    state_next = BK_EMIT;
            BK_EMIT:
                if (!rv_reg || res_ready)
                    state_next = BK_IDLE;
            default: state_next = BK_IDLE;
        endcase
    end

    // classify the latched job
    always_comb
    begin
        ev    = EV_UNHANDLED;
        e_ck  = 1'b1;
        e_off = 1'b0;
        e_rs  = 1'b0;
        if (job.kind == JOB_TIMEOUT)
        begin
            ev   = EV_TIMEOUT;
            e_ck = 1'b0;
        end
        else if (!job.ck_ok)
        begin
            e_ck  = 1'b0;
            e_off = 1'b1;
        end
        else if (job.hdr >= HDR_FB_LO && job.hdr <= HDR_FB_HI)
            ev = EV_FEEDBACK;
        else if (job.hdr == HDR_STAT && job.d1 == 8'h04)
            ev = EV_ACK;
        else if (job.hdr == HDR_STAT && job.d1 == 8'h01)
        begin
            ev    = EV_FAILURE;
            e_off = 1'b1;
        end
        else if (job.hdr == HDR_POWER && job.d1 == 8'h00)
            ev = EV_POWER_OFF;
        else if (job.hdr == HDR_POWER && job.d1 == 8'h01)
            ev = EV_POWER_ON;
        else if (job.hdr == HDR_TRAINS && job.d1 == 8'h00)
            ev = EV_TRAINS;
        else if (job.hdr == HDR_POWER && job.d1 == 8'h81)
        begin
            ev   = EV_BUSY;
            e_rs = pend_reg;
        end
    end

    logic [4:0] id0;
    logic [1:0] s0, s1;
    logic [31:0] map_sel;
    logic [3:0] blk;

    always_comb
    begin
        pidx_next  = pidx_reg;
        pairs_next = pairs_reg;
        swerr_next = swerr_reg;
        pend_next  = pend_reg;
        pwr_next   = pwr_reg;
        occ_next   = occ_reg;
        kn_next    = kn_reg;
        rd_ph_next = rd_ph_reg;
        rv_next    = rv_reg && !res_ready;
        res_next   = res_reg;
        emit       = 1'b0;
        for (int i = 0; i < NUM_SW; i++)
            sw_next[i] = sw_reg[i];
        id0     = 5'({addr_q[2:0], 2'b00}) + {3'd0, val_q[4], 1'b0};
        s0      = val_q[1:0];
        s1      = val_q[3:2];
        map_sel = (addr_q == FB_ADDR_A) ? map_a : map_b;
        blk     = 4'd0;

        if (job_valid && job_ready)
        begin
            pidx_next  = 3'd0;
            pairs_next = job.pairs;
            swerr_next = 1'b0;
            rd_ph_next = 1'b0;
            if (job.kind == JOB_ARM)
                pend_next = 1'b1;
            else if (job.kind == JOB_TIMEOUT)
                pend_next = 1'b0;
            else if (ev == EV_ACK)
                pend_next = 1'b0;
            else if (ev == EV_POWER_OFF)
                pwr_next = 1'b0;
            else if (ev == EV_POWER_ON)
                pwr_next = 1'b1;
            res_next.event_kind      = ev;
            res_next.checksum_ok     = e_ck;
            res_next.request_all_off = e_off;
            res_next.request_resend  = e_rs;
        end

        if (state_reg == BK_PAIR)
        begin
            rd_ph_next = !rd_ph_reg;
            // move on to the next pair once its value byte has been read
            if (!rd_ph_reg && pidx_reg != 3'd0)
                pidx_next = pidx_reg;
            if (rd_ph_reg)
                pidx_next = pidx_reg + 3'd1;
        end

        // apply the pair whose bytes are registered, in the cycle after the value read
        if (apply_reg)
        begin
            if (addr_q <= 8'd4)
            begin
                if (id0 < 5'(NUM_SW))
                begin
                    if (s0 == 2'd1 || s0 == 2'd2)
                    begin
                        sw_next[id0[3:0]] = s0;
                        if (id0 + 5'd1 < 5'(NUM_SW))
                        begin
                            if (s1 == 2'd1 || s1 == 2'd2)
                                sw_next[id0[3:0] + 4'd1] = s1;
                            else
                                swerr_next = 1'b1;
                        end
                    end
                    else
                        swerr_next = 1'b1;
                end
            end
            else if (addr_q == FB_ADDR_A || addr_q == FB_ADDR_B)
            begin
                for (int i = 0; i < 4; i++)
                begin
                    blk = map_sel[{val_q[4], 2'(i), 2'b00} +: 4];
                    if (blk < 4'(NUM_BLK))
                    begin
                        occ_next[blk] = val_q[i];
                        kn_next[blk]  = 1'b1;
                    end
                end
            end
        end

        if (state_reg == BK_EMIT && !apply_reg && (!rv_reg || res_ready))
        begin
            emit    = 1'b1;
            rv_next = 1'b1;
            res_next.track_power_on        = pwr_reg;
            res_next.command_pending       = pend_reg;
            res_next.switch_report_error   = swerr_reg;
            res_next.switch_state_vector   = '0;
            for (int i = 0; i < NUM_SW; i++)
                res_next.switch_state_vector[2*i +: 2] = sw_reg[i];
            res_next.block_occupied_vector = 14'(occ_reg);
            res_next.block_known_vector    = 14'(kn_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            apply_reg <= 1'b0;
        else
            apply_reg <= (state_reg == BK_PAIR) && rd_ph_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            pidx_reg  <= 3'd0;
            pairs_reg <= 3'd0;
            swerr_reg <= 1'b0;
            pend_reg  <= 1'b0;
            pwr_reg   <= 1'b0;
            occ_reg   <= '0;
            kn_reg    <= '0;
            rd_ph_reg <= 1'b0;
            rv_reg    <= 1'b0;
            for (int i = 0; i < NUM_SW; i++)
                sw_reg[i] <= 2'd0;
        end
        else
        begin
            state_reg <= (state_next == BK_IDLE && state_reg == BK_EMIT && !emit)
                         ? BK_EMIT : state_next;
            pidx_reg  <= pidx_next;
            pairs_reg <= pairs_next;
            swerr_reg <= swerr_next;
            pend_reg  <= pend_next;
            pwr_reg   <= pwr_next;
            occ_reg   <= occ_next;
            kn_reg    <= kn_next;
            rd_ph_reg <= rd_ph_next;
            rv_reg    <= rv_next;
            for (int i = 0; i < NUM_SW; i++)
                sw_reg[i] <= sw_next[i];
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

endmodule

### src/rail_bus_frame_receiver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rail_bus_frame_receiver
// Receive side of a serial rail bus link: frames, checks, classifies.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue (push/full) takes link bytes, millisecond ticks and notices
//   that a blocking command was sent. Result queue (empty/pop) gives one item
//   per frame end and per timeout of a pending command.
//   Config channel (cfg_valid/cfg_ready) writes timeout limit and the two
//   feedback block maps; write only while the block is idle.
// Flow:
//   The front end takes a plain byte whenever full is low, and full stays
//   high while its job waits for the back end. A frame end or tick that
//   yields a result is handed to the back end as a job and its item is
//   registered on the result port; a feedback frame first reads and applies
//   its pairs in turn via the one store read port, address then value byte.
// Reset: control state cleared, power off, nothing pending, registers at
//   their reset values. A stalled result holds; the back end then stalls
//   and the front end fills once more before raising full.
// ----------------------------------------------------------------------------
module rail_bus_frame_receiver (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  rbfr_pkg::in_item_t   in_item,
    output logic                 empty,
    input  logic                 pop,
    output rbfr_pkg::out_item_t  out_item,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [1:0]           cfg_index,
    input  logic [31:0]          cfg_data
);
    import rbfr_pkg::*;

    logic [15:0] tlim_reg;
    logic [31:0] map_a_reg, map_b_reg;
    logic        in_ready, job_valid, job_ready, res_valid;
    job_t        job;
    logic        st_we;
    logic [3:0]  st_waddr;
    logic [7:0]  st_wdata;

    assign cfg_ready = 1'b1;
    assign full      = !in_ready;
    assign empty     = !res_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tlim_reg  <= 16'd2000;
            map_a_reg <= 32'h7654_3210;
            map_b_reg <= 32'hDDDC_BA98;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_TIMEOUT: tlim_reg  <= cfg_data[15:0];
                REG_MAP_A:   map_a_reg <= cfg_data;
                REG_MAP_B:   map_b_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    rbfr_front u_front (
        .clk, .rst_n,
        .in_valid(push), .in_item, .in_ready,
        .timeout_limit(tlim_reg),
        .job_valid, .job, .job_ready,
        .st_we, .st_waddr, .st_wdata
    );

    rbfr_back u_back (
        .clk, .rst_n,
        .job_valid, .job, .job_ready,
        .map_a(map_a_reg), .map_b(map_b_reg),
        .st_we, .st_waddr, .st_wdata,
        .res_valid, .res(out_item), .res_ready(pop)
    );

endmodule

### src/rbfr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbfr_checker
// Port-level checks on the rail bus frame receiver.
// ----------------------------------------------------------------------------
module rbfr_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                empty,
    input logic                pop,
    input rbfr_pkg::out_item_t out_item
);
    import rbfr_pkg::*;

    // a waiting result holds until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(out_item))
        else $error("result changed while stalled");

    // no resend request outside a busy reply
    a_resend: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && out_item.request_resend |-> out_item.event_kind == EV_BUSY)
        else $error("resend outside busy");

    // switch error only with feedback
    a_swerr: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && out_item.switch_report_error |-> out_item.event_kind == EV_FEEDBACK)
        else $error("switch error outside feedback");

    // timeout never reports a good checksum
    a_tmo: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && out_item.event_kind == EV_TIMEOUT |-> !out_item.checksum_ok)
        else $error("timeout with checksum flag");

endmodule

bind rail_bus_frame_receiver rbfr_checker u_rbfr_checker (
    .clk, .rst_n, .empty, .pop, .out_item
);
